[design/gtb_pkg.sv]
`default_nettype none

package gtb_pkg;

    // Fraction bits of the internal fixed-point format
    localparam int FRAC     = 20;
    // Quotient bits of the tanh ratio and width of its divisor
    localparam int DIV_BITS = 21;
    localparam int DEN_W    = 42;

    localparam logic [20:0] ONE_Q    = 21'd1048576;
    localparam logic [19:0] C_Q      = 20'd836643;   // sqrt(2/pi)
    localparam logic [15:0] A_Q      = 16'd46887;    // 0.044715
    localparam logic [17:0] A3_Q     = 18'd140661;   // 3 * 0.044715
    localparam logic [22:0] TANH_SAT = 23'd5242880;  // 5.0

    // Pade [7/6] coefficients of tanh
    localparam logic [17:0] PADE_P0 = 18'd135135;
    localparam logic [14:0] PADE_P2 = 15'd17325;
    localparam logic [8:0]  PADE_P4 = 9'd378;
    localparam logic [15:0] PADE_Q2 = 16'd62370;
    localparam logic [11:0] PADE_Q4 = 12'd3150;
    localparam logic [4:0]  PADE_Q6 = 5'd28;

    typedef struct packed {
        logic signed [15:0] x_value;
        logic signed [15:0] grad_value;
    } t_in;

    typedef struct packed {
        logic signed [15:0] grad_in;
        logic               saturated;
    } t_out;

    // Per-item values that ride alongside the tanh divider
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] g;
        logic [25:0]        poly;
        logic [22:0]        u;
        logic               neg;
        logic               big;
    } t_side;

endpackage

`default_nettype wire

[design/gtb_div.sv]
`default_nettype none

module gtb_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_vld,
    input  wire logic [gtb_pkg::DEN_W-1:0]   i_rem,
    input  wire logic [gtb_pkg::DIV_BITS-1:0] i_low,
    input  wire logic [gtb_pkg::DEN_W-1:0]   i_den,
    input  wire gtb_pkg::t_side              i_side,
    output logic                             o_vld,
    output logic [gtb_pkg::DIV_BITS-1:0]     o_quo,
    output gtb_pkg::t_side                   o_side
);
    import gtb_pkg::*;

    logic                r_vld  [DIV_BITS];
    logic [DEN_W-1:0]    r_rem  [DIV_BITS];
    logic [DEN_W-1:0]    r_den  [DIV_BITS];
    logic [DIV_BITS-1:0] r_low  [DIV_BITS];
    logic [DIV_BITS-1:0] r_quo  [DIV_BITS];
    t_side               r_side [DIV_BITS];

    // One restoring step per stage: bring down a dividend bit, try the subtract
    for (genvar k = 0; k < DIV_BITS; k++) begin : g_step
        logic                vld_in;
        logic [DEN_W-1:0]    rem_in;
        logic [DEN_W-1:0]    den_in;
        logic [DIV_BITS-1:0] low_in;
        logic [DIV_BITS-1:0] quo_in;
        t_side               side_in;
        logic [DEN_W:0]      shl;
        logic [DEN_W-1:0]    n_rem;
        logic [DIV_BITS-1:0] n_quo;

        if (k == 0) begin : g_head
            assign vld_in  = i_vld;
            assign rem_in  = i_rem;
            assign den_in  = i_den;
            assign low_in  = i_low;
            assign quo_in  = '0;
            assign side_in = i_side;
        end else begin : g_body
            assign vld_in  = r_vld[k-1];
            assign rem_in  = r_rem[k-1];
            assign den_in  = r_den[k-1];
            assign low_in  = r_low[k-1];
            assign quo_in  = r_quo[k-1];
            assign side_in = r_side[k-1];
        end

        always_comb begin
            shl = {rem_in, low_in[DIV_BITS-1]};
            if (shl >= {1'b0, den_in}) begin
                n_rem = DEN_W'(shl - {1'b0, den_in});
                n_quo = {quo_in[DIV_BITS-2:0], 1'b1};
            end else begin
                n_rem = shl[DEN_W-1:0];
                n_quo = {quo_in[DIV_BITS-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= n_rem;
            r_den[k]  <= den_in;
            r_low[k]  <= {low_in[DIV_BITS-2:0], 1'b0};
            r_quo[k]  <= n_quo;
            r_side[k] <= side_in;
        end
    end

    assign o_vld  = r_vld[DIV_BITS-1];
    assign o_quo  = r_quo[DIV_BITS-1];
    assign o_side = r_side[DIV_BITS-1];

endmodule

`default_nettype wire

[design/gelu_tanh_backward.sv]
`default_nettype none

// GELU backward (tanh form) in Q4.11. Pulse start with one beat on i_data
// (activation x and upstream gradient); the block takes a beat on every clock,
// busy never rises, and o_done marks the matching beat on o_result once it
// has left the last pipeline stage, in order, for one cycle only since the
// receiver cannot hold it off. In the pipeline, a capture stage and ten more
// stages build the tanh argument, the Pade polynomials and the dividend, the
// tanh ratio runs through a 21-stage restoring divider (one quotient bit per
// stage), and eight more stages form the derivative, multiply by the gradient
// and saturate.
// grad_in clips to the Q4.11 range and saturated flags each clipped beat.
module gelu_tanh_backward (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire gtb_pkg::t_in  i_data,
    output logic               o_done,
    output gtb_pkg::t_out      o_result
);
    import gtb_pkg::*;

    localparam int PRE  = 11;  // stages ahead of the divider
    localparam int POST = 8;   // stages after the divider

    logic            n_accept;
    logic [PRE-1:0]  r_pre_vld;
    logic [POST-1:0] r_post_vld;

    // Fully pipelined: never stall the sender
    assign busy     = 1'b0;
    assign n_accept = start & ~busy;

    // ---------------- stage 1: capture the beat ----------------
    logic signed [15:0] r_s1_x, r_s1_g;

    // ---------------- stage 2: x^2 ----------------
    logic signed [31:0] s2_sq;
    logic [31:0]        s2_rnd;
    logic [28:0]        n_s2_x2, r_s2_x2;
    logic signed [15:0] r_s2_x, r_s2_g;

    assign s2_sq   = r_s1_x * r_s1_x;
    assign s2_rnd  = unsigned'(s2_sq) + 32'd2;
    assign n_s2_x2 = s2_rnd[30:2];

    // ---------------- stage 3: x^3 and 1 + 3a*x^2 ----------------
    logic signed [45:0] s3_p;
    logic [45:0]        s3_r;
    logic [46:0]        s3_pa, s3_pr;
    logic signed [32:0] n_s3_x3, r_s3_x3;
    logic [25:0]        n_s3_poly, r_s3_poly;
    logic signed [15:0] r_s3_x, r_s3_g;

    assign s3_p      = $signed({1'b0, r_s2_x2}) * r_s2_x;
    assign s3_r      = s3_p + 46'sd1024 - 46'(s3_p[45]);
    assign n_s3_x3   = s3_r[43:11];
    assign s3_pa     = 47'(A3_Q) * 47'(r_s2_x2);
    assign s3_pr     = s3_pa + 47'd524288;
    assign n_s3_poly = s3_pr[45:20] + 26'(ONE_Q);

    // ---------------- stage 4: x + a*x^3 ----------------
    logic signed [49:0] s4_p;
    logic [49:0]        s4_r;
    logic signed [28:0] s4_ax;
    logic signed [28:0] n_s4_s, r_s4_s;
    logic signed [15:0] r_s4_x, r_s4_g;
    logic [25:0]        r_s4_poly;

    assign s4_p   = $signed({1'b0, A_Q}) * r_s3_x3;
    assign s4_r   = s4_p + 50'sd524288 - 50'(s4_p[49]);
    assign s4_ax  = s4_r[48:20];
    assign n_s4_s = s4_ax + {{4{r_s3_x[15]}}, r_s3_x, 9'd0};

    // ---------------- stage 5: v = c*(x + a*x^3) ----------------
    logic signed [49:0] s5_p;
    logic [49:0]        s5_r;
    logic signed [28:0] n_s5_v, r_s5_v;
    logic signed [15:0] r_s5_x, r_s5_g;
    logic [25:0]        r_s5_poly;

    assign s5_p   = $signed({1'b0, C_Q}) * r_s4_s;
    assign s5_r   = s5_p + 50'sd524288 - 50'(s5_p[49]);
    assign n_s5_v = s5_r[48:20];

    // ---------------- stage 6: |v|, sign, saturation test ----------------
    logic [27:0] s6_mag;
    t_side       n_s6_side, r_s6_side;

    assign s6_mag = r_s5_v[28] ? 28'(-r_s5_v) : r_s5_v[27:0];

    always_comb begin
        n_s6_side.x    = r_s5_x;
        n_s6_side.g    = r_s5_g;
        n_s6_side.poly = r_s5_poly;
        n_s6_side.u    = s6_mag[22:0];
        n_s6_side.neg  = r_s5_v[28];
        n_s6_side.big  = s6_mag >= 28'(TANH_SAT);
    end

    // ---------------- stages 7..9: u^2, u^4, u^6 ----------------
    logic [45:0] s7_r;
    logic [24:0] n_s7_u2, r_s7_u2;
    t_side       r_s7_side;

    assign s7_r    = 46'(r_s6_side.u) * 46'(r_s6_side.u) + 46'd524288;
    assign n_s7_u2 = s7_r[44:20];

    logic [49:0] s8_r;
    logic [29:0] n_s8_u4, r_s8_u4;
    logic [24:0] r_s8_u2;
    t_side       r_s8_side;

    assign s8_r    = 50'(r_s7_u2) * 50'(r_s7_u2) + 50'd524288;
    assign n_s8_u4 = s8_r[49:20];

    logic [54:0] s9_r;
    logic [33:0] n_s9_u6, r_s9_u6;
    logic [29:0] r_s9_u4;
    logic [24:0] r_s9_u2;
    t_side       r_s9_side;

    assign s9_r    = 55'(r_s8_u4) * 55'(r_s8_u2) + 55'd524288;
    assign n_s9_u6 = s9_r[53:20];

    // ---------------- stage 10: Pade numerator and denominator ----------------
    logic [43:0]      s10_p, s10_q;
    logic [39:0]      n_s10_p, r_s10_p;
    logic [DEN_W-1:0] n_s10_q, r_s10_q;
    t_side            r_s10_side;

    assign s10_p = (44'(PADE_P0) << FRAC) + 44'(PADE_P2) * 44'(r_s9_u2)
                 + 44'(PADE_P4) * 44'(r_s9_u4) + 44'(r_s9_u6);
    assign s10_q = (44'(PADE_Q2) * 44'(r_s9_u2) + (44'(PADE_P0) << FRAC))
                 + 44'(PADE_Q4) * 44'(r_s9_u4) + 44'(PADE_Q6) * 44'(r_s9_u6);
    assign n_s10_p = s10_p[39:0];
    assign n_s10_q = s10_q[DEN_W-1:0];

    // ---------------- stage 11: rounded dividend, split for the divider ----------------
    logic [60:0]         s11_n;
    logic [39:0]         n_s11_rem, r_s11_rem;
    logic [DIV_BITS-1:0] n_s11_low, r_s11_low;
    logic [DEN_W-1:0]    r_s11_q;
    t_side               r_s11_side;

    assign s11_n     = {1'b0, r_s10_p, 20'd0} + 61'(r_s10_q >> 1);
    assign n_s11_rem = s11_n[60:21];
    assign n_s11_low = s11_n[20:0];

    // ---------------- stages 12..32: tanh ratio ----------------
    logic                div_vld;
    logic [DIV_BITS-1:0] div_quo;
    t_side               div_side;

    gtb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_pre_vld[PRE-1]),
        .i_rem   (DEN_W'(r_s11_rem)),
        .i_low   (r_s11_low),
        .i_den   (r_s11_q),
        .i_side  (r_s11_side),
        .o_vld   (div_vld),
        .o_quo   (div_quo),
        .o_side  (div_side)
    );

    // ---------------- post stage A: |tanh| = u * ratio, clamped ----------------
    logic [43:0] sa_r;
    logic [23:0] sa_t;
    logic [20:0] n_sa_mag, r_sa_mag;
    t_side       r_sa_side;

    assign sa_r     = 44'(div_side.u) * 44'(div_quo) + 44'd524288;
    assign sa_t     = sa_r[43:20];
    assign n_sa_mag = (div_side.big || sa_t > 24'(ONE_Q)) ? ONE_Q : sa_t[20:0];

    // ---------------- post stage B: (1+t)/2 and 1 - t^2 ----------------
    logic signed [21:0] sb_t;
    logic signed [22:0] sb_sum;
    logic [41:0]        sb_sq;
    logic [20:0]        n_sb_term1, r_sb_term1;
    logic [20:0]        n_sb_sech2, r_sb_sech2;
    t_side              r_sb_side;

    assign sb_t       = r_sa_side.neg ? -$signed({1'b0, r_sa_mag}) : $signed({1'b0, r_sa_mag});
    assign sb_sum     = $signed({2'b0, ONE_Q}) + 23'(sb_t) + 23'sd1;
    assign n_sb_term1 = sb_sum[21:1];
    assign sb_sq      = 42'(r_sa_mag) * 42'(r_sa_mag) + 42'd524288;
    assign n_sb_sech2 = ONE_Q - sb_sq[40:20];

    // ---------------- post stage C: c * (1 - t^2) ----------------
    logic [40:0] sc_r;
    logic [19:0] n_sc_m1, r_sc_m1;
    logic [20:0] r_sc_term1;
    t_side       r_sc_side;

    assign sc_r    = 41'(C_Q) * 41'(r_sb_sech2) + 41'd524288;
    assign n_sc_m1 = sc_r[39:20];

    // ---------------- post stage D: times (1 + 3a*x^2) ----------------
    logic [45:0] sd_r;
    logic [24:0] n_sd_m2, r_sd_m2;
    logic [20:0] r_sd_term1;
    t_side       r_sd_side;

    assign sd_r    = 46'(r_sc_m1) * 46'(r_sc_side.poly) + 46'd524288;
    assign n_sd_m2 = sd_r[44:20];

    // ---------------- post stage E: times x ----------------
    logic signed [41:0] se_p;
    logic [41:0]        se_r;
    logic signed [29:0] n_se_m3, r_se_m3;
    logic [20:0]        r_se_term1;
    t_side              r_se_side;

    assign se_p    = $signed({1'b0, r_sd_m2}) * r_sd_side.x;
    assign se_r    = se_p + 42'sd1024 - 42'(se_p[41]);
    assign n_se_m3 = se_r[40:11];

    // ---------------- post stage F: halve and add, derivative d ----------------
    logic [29:0]        sf_r;
    logic signed [28:0] sf_t2;
    logic signed [29:0] n_sf_d, r_sf_d;
    t_side              r_sf_side;

    assign sf_r   = r_se_m3 + 30'sd1 - 30'(r_se_m3[29]);
    assign sf_t2  = sf_r[29:1];
    assign n_sf_d = 30'(sf_t2) + 30'(r_se_term1);

    // ---------------- post stage G: gradient times d ----------------
    logic signed [45:0] n_sg_pm, r_sg_pm;

    assign n_sg_pm = r_sf_d * r_sf_side.g;

    // ---------------- post stage H: back to Q4.11, saturate ----------------
    logic [45:0]        sh_r;
    logic signed [25:0] sh_pr;
    t_out               n_out, r_out;

    assign sh_r  = r_sg_pm + 46'sd524288 - 46'(r_sg_pm[45]);
    assign sh_pr = sh_r[45:20];

    always_comb begin
        if (sh_pr > 26'sd32767) begin
            n_out.grad_in   = 16'sh7FFF;
            n_out.saturated = 1'b1;
        end else if (sh_pr < -26'sd32768) begin
            n_out.grad_in   = -16'sh8000;
            n_out.saturated = 1'b1;
        end else begin
            n_out.grad_in   = sh_pr[15:0];
            n_out.saturated = 1'b0;
        end
    end

    // Valid bits advance with the data; reset drops everything in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_vld  <= '0;
            r_post_vld <= '0;
        end else begin
            r_pre_vld  <= {r_pre_vld[PRE-2:0], n_accept};
            r_post_vld <= {r_post_vld[POST-2:0], div_vld};
        end
    end

    // Payload pipeline: load every cycle, the valid bits say what counts
    always_ff @(posedge i_clk) begin
        r_s1_x     <= i_data.x_value;
        r_s1_g     <= i_data.grad_value;

        r_s2_x2    <= n_s2_x2;
        r_s2_x     <= r_s1_x;
        r_s2_g     <= r_s1_g;

        r_s3_x3    <= n_s3_x3;
        r_s3_poly  <= n_s3_poly;
        r_s3_x     <= r_s2_x;
        r_s3_g     <= r_s2_g;

        r_s4_s     <= n_s4_s;
        r_s4_poly  <= r_s3_poly;
        r_s4_x     <= r_s3_x;
        r_s4_g     <= r_s3_g;

        r_s5_v     <= n_s5_v;
        r_s5_poly  <= r_s4_poly;
        r_s5_x     <= r_s4_x;
        r_s5_g     <= r_s4_g;

        r_s6_side  <= n_s6_side;

        r_s7_u2    <= n_s7_u2;
        r_s7_side  <= r_s6_side;

        r_s8_u4    <= n_s8_u4;
        r_s8_u2    <= r_s7_u2;
        r_s8_side  <= r_s7_side;

        r_s9_u6    <= n_s9_u6;
        r_s9_u4    <= r_s8_u4;
        r_s9_u2    <= r_s8_u2;
        r_s9_side  <= r_s8_side;

        r_s10_p    <= n_s10_p;
        r_s10_q    <= n_s10_q;
        r_s10_side <= r_s9_side;

        r_s11_rem  <= n_s11_rem;
        r_s11_low  <= n_s11_low;
        r_s11_q    <= r_s10_q;
        r_s11_side <= r_s10_side;

        r_sa_mag   <= n_sa_mag;
        r_sa_side  <= div_side;

        r_sb_term1 <= n_sb_term1;
        r_sb_sech2 <= n_sb_sech2;
        r_sb_side  <= r_sa_side;

        r_sc_m1    <= n_sc_m1;
        r_sc_term1 <= r_sb_term1;
        r_sc_side  <= r_sb_side;

        r_sd_m2    <= n_sd_m2;
        r_sd_term1 <= r_sc_term1;
        r_sd_side  <= r_sc_side;

        r_se_m3    <= n_se_m3;
        r_se_term1 <= r_sd_term1;
        r_se_side  <= r_sd_side;

        r_sf_d     <= n_sf_d;
        r_sf_side  <= r_se_side;

        r_sg_pm    <= n_sg_pm;

        r_out      <= n_out;
    end

    assign o_done   = r_post_vld[POST-1];
    assign o_result = r_out;

endmodule

`default_nettype wire
